FILE: design/axis_table_polar_lookup_macros.svh
// ----------------------------------------------------------------------------
// axis_table_polar_lookup assertion macros
// Shared assertion forms for the axis table checker.
// ----------------------------------------------------------------------------
`ifndef AXIS_TABLE_POLAR_LOOKUP_MACROS_SVH
`define AXIS_TABLE_POLAR_LOOKUP_MACROS_SVH

// Checked while out of reset.
`define ATPL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ATPL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/atpl_pkg.sv
// ----------------------------------------------------------------------------
// atpl_pkg
// Types, constants and tables for the axis table polar lookup.
// ----------------------------------------------------------------------------
package atpl_pkg;

  localparam int MAX_POINTS = 64;
  localparam int PTR_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int MUL_W   = DIFF_W + 1;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int T_W     = 17;
  localparam int REM_W   = DIFF_W + 2;
  localparam int ANG_W   = 16;
  localparam int DIST_W  = 25;

  localparam int CORDIC_ITERS = 24;
  localparam int SQRT_STEPS   = 25;
  localparam int STEP_W       = 5;
  localparam int CW_W         = 58;
  localparam int ACC_W        = 28;

  localparam logic signed [ACC_W-1:0] PI_Q24       = 28'sd52707179;
  localparam logic signed [T_W-1:0]   ANGLE_LIMIT  = 17'sd25736;
  localparam logic signed [ACC_W-1:0] ANGLE_ROUND  = 28'sd1024;

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_CLEAR  = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } entry_t;

  typedef struct packed {
    logic                     start;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dx;
    logic [SQ_W-1:0]          sumsq;
  } polar_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [ANG_W-1:0] angle;
    logic [DIST_W-1:0]       distance;
  } polar_rsp_t;

  // atan(2^-i) in units of 2^-24 rad
  function automatic logic signed [ACC_W-1:0] atan_q24(input logic [STEP_W-1:0] i);
    logic signed [ACC_W-1:0] v;
    unique case (i)
      5'd0:    v = 28'sd13176795;
      5'd1:    v = 28'sd7778716;
      5'd2:    v = 28'sd4110060;
      5'd3:    v = 28'sd2086331;
      5'd4:    v = 28'sd1047214;
      5'd5:    v = 28'sd524117;
      5'd6:    v = 28'sd262123;
      5'd7:    v = 28'sd131069;
      5'd8:    v = 28'sd65536;
      5'd9:    v = 28'sd32768;
      5'd10:   v = 28'sd16384;
      5'd11:   v = 28'sd8192;
      5'd12:   v = 28'sd4096;
      5'd13:   v = 28'sd2048;
      5'd14:   v = 28'sd1024;
      5'd15:   v = 28'sd512;
      5'd16:   v = 28'sd256;
      5'd17:   v = 28'sd128;
      5'd18:   v = 28'sd64;
      5'd19:   v = 28'sd32;
      5'd20:   v = 28'sd16;
      5'd21:   v = 28'sd8;
      5'd22:   v = 28'sd4;
      5'd23:   v = 28'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: design/atpl_if.sv
// ----------------------------------------------------------------------------
// atpl channel interfaces
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface atpl_in_if import atpl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                req_type;
  logic signed [COORD_W-1:0] coord_z;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_x;

  modport source (output valid, req_type, coord_z, coord_y, coord_x, input ready);
  modport sink   (input valid, req_type, coord_z, coord_y, coord_x, output ready);
endinterface

interface atpl_out_if import atpl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      status;
  logic signed [COORD_W-1:0] center_y;
  logic signed [COORD_W-1:0] center_x;
  logic signed [ANG_W-1:0]   angle;
  logic [DIST_W-1:0]         distance;
  logic [CNT_W-1:0]          point_total;

  modport source (output valid, status, center_y, center_x, angle, distance, point_total,
                  input ready);
  modport sink   (input valid, status, center_y, center_x, angle, distance, point_total,
                  output ready);
endinterface

FILE: design/atpl_polar.sv
// ----------------------------------------------------------------------------
// atpl_polar
// Iterative CORDIC atan2 and digit-by-digit square root, one step a cycle.
// ----------------------------------------------------------------------------
module atpl_polar import atpl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  polar_req_t req,
  output polar_rsp_t rsp
);

  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [STEP_W-1:0]        cnt_r, cnt_nxt;
  logic signed [CW_W-1:0]   x_r, x_nxt, y_r, y_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic                     zero_r, zero_nxt;
  logic [DIST_W-1:0]        root_r, root_nxt;
  logic [DIST_W+2:0]        rem_r, rem_nxt;
  logic [SQ_W-1:0]          sq_r, sq_nxt;

  logic signed [CW_W-1:0]   x_init, y_init, x_sh, y_sh;
  logic [DIST_W+2:0]        rem_s, trial;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [T_W-1:0]    ang_q;
  logic signed [ANG_W-1:0]  ang_c;

  assign x_init = CW_W'(req.dx) <<< 30;
  assign y_init = CW_W'(req.dy) <<< 30;
  assign x_sh   = x_r >>> cnt_r;
  assign y_sh   = y_r >>> cnt_r;
  assign rem_s  = {rem_r[DIST_W:0], sq_r[SQ_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    zero_nxt = zero_r;
    root_nxt = root_r;
    rem_nxt  = rem_r;
    sq_nxt   = sq_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      zero_nxt = (req.dx == '0) && (req.dy == '0);
      root_nxt = '0;
      rem_nxt  = '0;
      sq_nxt   = req.sumsq;
      if (req.dx < 0) begin
        // turn by pi so the vector lands in the right half plane
        x_nxt   = -x_init;
        y_nxt   = -y_init;
        acc_nxt = (req.dy >= 0) ? PI_Q24 : -PI_Q24;
      end else begin
        x_nxt   = x_init;
        y_nxt   = y_init;
        acc_nxt = '0;
      end
    end else if (busy_r) begin
      if (cnt_r < STEP_W'(CORDIC_ITERS)) begin
        if (y_r > 0) begin
          x_nxt   = x_r + y_sh;
          y_nxt   = y_r - x_sh;
          acc_nxt = acc_r + atan_q24(cnt_r);
        end else begin
          x_nxt   = x_r - y_sh;
          y_nxt   = y_r + x_sh;
          acc_nxt = acc_r - atan_q24(cnt_r);
        end
      end
      sq_nxt = {sq_r[SQ_W-3:0], 2'b00};
      if (rem_s >= trial) begin
        rem_nxt  = rem_s - trial;
        root_nxt = {root_r[DIST_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_s;
        root_nxt = {root_r[DIST_W-2:0], 1'b0};
      end
      if (cnt_r == STEP_W'(SQRT_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    acc_r  <= acc_nxt;
    zero_r <= zero_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
    sq_r   <= sq_nxt;
  end

  // round to 2^-13 rad, halves up, then clamp
  assign acc_rnd = acc_r + ANGLE_ROUND;
  assign ang_q   = acc_rnd[ACC_W-1:11];

  always_comb begin
    if (zero_r) begin
      ang_c = '0;
    end else if (ang_q > ANGLE_LIMIT) begin
      ang_c = ANG_W'(ANGLE_LIMIT);
    end else if (ang_q < -ANGLE_LIMIT) begin
      ang_c = ANG_W'(-ANGLE_LIMIT);
    end else begin
      ang_c = ang_q[ANG_W-1:0];
    end
  end

  assign rsp.done     = done_r;
  assign rsp.angle    = ang_c;
  assign rsp.distance = root_r + DIST_W'(rem_r > {3'b000, root_r});

endmodule

FILE: design/axis_table_polar_lookup.sv
// ----------------------------------------------------------------------------
// axis_table_polar_lookup
// Sorted axis control point table with interpolated polar lookup.
// ----------------------------------------------------------------------------
// Holds up to MAX_POINTS (z, y, x) points sorted by z in a single-port-write
// memory. One request is in work at a time. The output register decouples
// the two sides: a result waiting there does not hold off the next request,
// but that request stalls in its final load cycle until the register frees.
// Steps per request, from accept until ready again, with n points held:
//   clear, unused code, dropped insert: accept, result load.
//   insert into an empty table: accept, result load.
//   insert otherwise: m entries with larger z (0..n) move up one slot,
//   one entry per cycle through the memory read port.
//   query on an empty table: no end checks and no table scan.
//   query clamped to the first point or to the last point: end checks only.
//   interpolated query: setup/end checks, s table scan reads (1..n-1),
//   17 divide steps, the multiplier work (two interpolation products,
//   two squares and the sum), start, 25 CORDIC/sqrt steps, then done,
//   and the result load.
// The divide is a restoring divider, one quotient bit per cycle, and one
// 26x26 multiplier serves the interpolation and both squares.
// ----------------------------------------------------------------------------
module axis_table_polar_lookup import atpl_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  atpl_in_if.sink    in_ch,
  atpl_out_if.source out_ch
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_CMP = 4'd1;
  localparam logic [3:0] S_INS_PUT = 4'd2;
  localparam logic [3:0] S_Q_CHK0  = 4'd3;
  localparam logic [3:0] S_Q_CHKL  = 4'd4;
  localparam logic [3:0] S_Q_SCAN  = 4'd5;
  localparam logic [3:0] S_DIV     = 4'd6;
  localparam logic [3:0] S_MUL_Y   = 4'd7;
  localparam logic [3:0] S_MUL_X   = 4'd8;
  localparam logic [3:0] S_CX      = 4'd9;
  localparam logic [3:0] S_SQ_Y    = 4'd10;
  localparam logic [3:0] S_SQ_X    = 4'd11;
  localparam logic [3:0] S_SQ_SUM  = 4'd12;
  localparam logic [3:0] S_P_START = 4'd13;
  localparam logic [3:0] S_POLAR   = 4'd14;
  localparam logic [3:0] S_DONE    = 4'd15;

  localparam int DIV_STEPS = T_W;

  // table memory
  entry_t           mem_r [MAX_POINTS];
  entry_t           rd_data_r;
  logic             we_c;
  logic [PTR_W-1:0] wa_c, ra_c;
  entry_t           wd_c;

  logic [3:0]                state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [CNT_W-1:0]          k_r, k_nxt;
  logic signed [COORD_W-1:0] qz_r, qz_nxt, qy_r, qy_nxt, qx_r, qx_nxt;
  entry_t                    lo_r, lo_nxt, hi_r, hi_nxt;
  logic [REM_W-1:0]          rem_r, rem_nxt;
  logic [DIFF_W-1:0]         den_r, den_nxt;
  logic [T_W-1:0]            t_r, t_nxt;
  logic [STEP_W-1:0]         dcnt_r, dcnt_nxt;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [COORD_W-1:0] cy_r, cy_nxt, cx_r, cx_nxt;
  logic [SQ_W-1:0]           sum_r, sum_nxt;
  logic                      stat_r, stat_nxt;
  logic signed [ANG_W-1:0]   ang_r, ang_nxt;
  logic [DIST_W-1:0]         dist_r, dist_nxt;

  // output register
  logic                      out_valid_r, out_valid_nxt;
  logic                      o_stat_r, o_stat_nxt;
  logic signed [COORD_W-1:0] o_cy_r, o_cy_nxt, o_cx_r, o_cx_nxt;
  logic signed [ANG_W-1:0]   o_ang_r, o_ang_nxt;
  logic [DIST_W-1:0]         o_dist_r, o_dist_nxt;
  logic [CNT_W-1:0]          o_tot_r, o_tot_nxt;

  logic signed [MUL_W-1:0]   mul_a_c, mul_b_c;
  logic signed [DIFF_W-1:0]  dy_c, dx_c;
  logic [REM_W-1:0]          rem_s;
  logic                      accept;
  entry_t                    new_c;
  polar_req_t                preq;
  polar_rsp_t                prsp;

  assign accept = in_ch.valid && in_ch.ready;
  assign dy_c   = DIFF_W'(qy_r) - DIFF_W'(cy_r);
  assign dx_c   = DIFF_W'(qx_r) - DIFF_W'(cx_r);
  assign new_c  = '{z: qz_r, y: qy_r, x: qx_r};
  assign rem_s  = (dcnt_r == '0) ? rem_r : {rem_r[REM_W-2:0], 1'b0};

  atpl_polar u_polar (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (preq),
    .rsp   (prsp)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    qz_nxt    = qz_r;
    qy_nxt    = qy_r;
    qx_nxt    = qx_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    t_nxt     = t_r;
    dcnt_nxt  = dcnt_r;
    cy_nxt    = cy_r;
    cx_nxt    = cx_r;
    sum_nxt   = sum_r;
    stat_nxt  = stat_r;
    ang_nxt   = ang_r;
    dist_nxt  = dist_r;
    we_c      = 1'b0;
    wa_c      = '0;
    wd_c      = new_c;
    ra_c      = '0;
    mul_a_c   = '0;
    mul_b_c   = '0;
    preq      = '{start: 1'b0, dy: dy_c, dx: dx_c, sumsq: sum_r};

    out_valid_nxt = out_valid_r && !out_ch.ready;
    o_stat_nxt    = o_stat_r;
    o_cy_nxt      = o_cy_r;
    o_cx_nxt      = o_cx_r;
    o_ang_nxt     = o_ang_r;
    o_dist_nxt    = o_dist_r;
    o_tot_nxt     = o_tot_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          qz_nxt   = in_ch.coord_z;
          qy_nxt   = in_ch.coord_y;
          qx_nxt   = in_ch.coord_x;
          stat_nxt = 1'b0;
          cy_nxt   = '0;
          cx_nxt   = '0;
          ang_nxt  = '0;
          dist_nxt = '0;
          state_nxt = S_DONE;
          priority if (in_ch.req_type == REQ_INSERT) begin
            if (cnt_r == CNT_W'(MAX_POINTS)) begin
              stat_nxt = 1'b1;
            end else if (cnt_r == '0) begin
              we_c    = 1'b1;
              wd_c    = '{z: in_ch.coord_z, y: in_ch.coord_y, x: in_ch.coord_x};
              cnt_nxt = cnt_r + 1'b1;
            end else begin
              // walk down from the top, moving larger z up one slot
              ra_c      = PTR_W'(cnt_r - 1'b1);
              k_nxt     = cnt_r;
              state_nxt = S_INS_CMP;
            end
          end else if (in_ch.req_type == REQ_CLEAR) begin
            cnt_nxt = '0;
          end else if (in_ch.req_type == REQ_QUERY) begin
            ra_c      = '0;
            state_nxt = (cnt_r == '0) ? S_SQ_Y : S_Q_CHK0;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_INS_CMP: begin
        if (rd_data_r.z > qz_r) begin
          we_c  = 1'b1;
          wa_c  = k_r[PTR_W-1:0];
          wd_c  = rd_data_r;
          k_nxt = k_r - 1'b1;
          if (k_r == CNT_W'(1)) begin
            state_nxt = S_INS_PUT;
          end else begin
            ra_c = PTR_W'(k_r - CNT_W'(2));
          end
        end else begin
          we_c      = 1'b1;
          wa_c      = k_r[PTR_W-1:0];
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_DONE;
        end
      end

      S_INS_PUT: begin
        we_c      = 1'b1;
        wa_c      = k_r[PTR_W-1:0];
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = S_DONE;
      end

      S_Q_CHK0: begin
        // single point or at or below the first z: take the first point
        if (cnt_r == CNT_W'(1) || qz_r <= rd_data_r.z) begin
          cy_nxt    = rd_data_r.y;
          cx_nxt    = rd_data_r.x;
          state_nxt = S_SQ_Y;
        end else begin
          lo_nxt    = rd_data_r;
          ra_c      = PTR_W'(cnt_r - 1'b1);
          state_nxt = S_Q_CHKL;
        end
      end

      S_Q_CHKL: begin
        // at or above the last z: take the last point
        if (qz_r >= rd_data_r.z) begin
          cy_nxt    = rd_data_r.y;
          cx_nxt    = rd_data_r.x;
          state_nxt = S_SQ_Y;
        end else begin
          ra_c      = PTR_W'(1);
          k_nxt     = CNT_W'(1);
          state_nxt = S_Q_SCAN;
        end
      end

      S_Q_SCAN: begin
        if ((k_r < CNT_W'(cnt_r - 1'b1)) && (rd_data_r.z < qz_r)) begin
          lo_nxt = rd_data_r;
          k_nxt  = k_r + 1'b1;
          ra_c   = PTR_W'(k_r + 1'b1);
        end else begin
          // bracketing segment found, lo.z < qz <= hi.z
          hi_nxt    = rd_data_r;
          rem_nxt   = REM_W'(qz_r) - REM_W'(lo_r.z);
          den_nxt   = DIFF_W'(rd_data_r.z) - DIFF_W'(lo_r.z);
          t_nxt     = '0;
          dcnt_nxt  = '0;
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        // restoring divide, one quotient bit per cycle
        if (rem_s >= REM_W'(den_r)) begin
          rem_nxt = rem_s - REM_W'(den_r);
          t_nxt   = {t_r[T_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_s;
          t_nxt   = {t_r[T_W-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_MUL_Y;
        end
      end

      S_MUL_Y: begin
        mul_a_c   = MUL_W'(t_r);
        mul_b_c   = MUL_W'(DIFF_W'(hi_r.y) - DIFF_W'(lo_r.y));
        state_nxt = S_MUL_X;
      end

      S_MUL_X: begin
        cy_nxt    = lo_r.y + prod_r[COORD_W+15:16];
        mul_a_c   = MUL_W'(t_r);
        mul_b_c   = MUL_W'(DIFF_W'(hi_r.x) - DIFF_W'(lo_r.x));
        state_nxt = S_CX;
      end

      S_CX: begin
        cx_nxt    = lo_r.x + prod_r[COORD_W+15:16];
        state_nxt = S_SQ_Y;
      end

      S_SQ_Y: begin
        mul_a_c   = MUL_W'(dy_c);
        mul_b_c   = MUL_W'(dy_c);
        state_nxt = S_SQ_X;
      end

      S_SQ_X: begin
        sum_nxt   = prod_r[SQ_W-1:0];
        mul_a_c   = MUL_W'(dx_c);
        mul_b_c   = MUL_W'(dx_c);
        state_nxt = S_SQ_SUM;
      end

      S_SQ_SUM: begin
        sum_nxt   = sum_r + prod_r[SQ_W-1:0];
        state_nxt = S_P_START;
      end

      S_P_START: begin
        preq.start = 1'b1;
        state_nxt  = S_POLAR;
      end

      S_POLAR: begin
        if (prsp.done) begin
          ang_nxt   = prsp.angle;
          dist_nxt  = prsp.distance;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          o_stat_nxt    = stat_r;
          o_cy_nxt      = cy_r;
          o_cx_nxt      = cx_r;
          o_ang_nxt     = ang_r;
          o_dist_nxt    = dist_r;
          o_tot_nxt     = cnt_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_c) begin
      mem_r[wa_c] <= wd_c;
    end
    rd_data_r <= mem_r[ra_c];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    k_r      <= k_nxt;
    qz_r     <= qz_nxt;
    qy_r     <= qy_nxt;
    qx_r     <= qx_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    rem_r    <= rem_nxt;
    den_r    <= den_nxt;
    t_r      <= t_nxt;
    dcnt_r   <= dcnt_nxt;
    prod_r   <= mul_a_c * mul_b_c;
    cy_r     <= cy_nxt;
    cx_r     <= cx_nxt;
    sum_r    <= sum_nxt;
    stat_r   <= stat_nxt;
    ang_r    <= ang_nxt;
    dist_r   <= dist_nxt;
    o_stat_r <= o_stat_nxt;
    o_cy_r   <= o_cy_nxt;
    o_cx_r   <= o_cx_nxt;
    o_ang_r  <= o_ang_nxt;
    o_dist_r <= o_dist_nxt;
    o_tot_r  <= o_tot_nxt;
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = o_stat_r;
  assign out_ch.center_y    = o_cy_r;
  assign out_ch.center_x    = o_cx_r;
  assign out_ch.angle       = o_ang_r;
  assign out_ch.distance    = o_dist_r;
  assign out_ch.point_total = o_tot_r;

endmodule

FILE: design/atpl_checker.sv
// ----------------------------------------------------------------------------
// atpl_checker
// Port-level checks on the axis table polar lookup result channel.
// ----------------------------------------------------------------------------
`include "axis_table_polar_lookup_macros.svh"

module atpl_checker import atpl_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_status,
  input logic signed [COORD_W-1:0] out_center_y,
  input logic signed [COORD_W-1:0] out_center_x,
  input logic signed [ANG_W-1:0]   out_angle,
  input logic [DIST_W-1:0]         out_distance,
  input logic [CNT_W-1:0]          out_point_total
);

  `ATPL_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_angle) && $stable(out_distance) && $stable(out_point_total), "result changed while stalled")
  `ATPL_ASSERT(a_total_max, out_valid |-> out_point_total <= CNT_W'(MAX_POINTS), "point total above table size")
  `ATPL_ASSERT(a_full_drop, out_valid && out_status |-> out_point_total == CNT_W'(MAX_POINTS) && out_center_y == '0 && out_center_x == '0 && out_angle == '0 && out_distance == '0, "dropped insert with bad fields")
  `ATPL_ASSERT(a_angle_range, out_valid |-> out_angle <= 16'sd25736 && out_angle >= -16'sd25736, "angle out of range")
  `ATPL_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind axis_table_polar_lookup atpl_checker u_atpl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_center_y    (out_ch.center_y),
  .out_center_x    (out_ch.center_x),
  .out_angle       (out_ch.angle),
  .out_distance    (out_ch.distance),
  .out_point_total (out_ch.point_total)
);

FILE: dv/tb_axis_table_polar_lookup.sv
// ----------------------------------------------------------------------------
// tb_axis_table_polar_lookup
// Self-checking bench for the sorted axis table with polar lookup.
// ----------------------------------------------------------------------------
// Requests go in through one valid/ready channel. At each accepted request a
// local table model predicts the single result: insert ordering, the full
// table, clear, unused codes, and for queries the interpolated center, the
// CORDIC angle and the rounded distance. Results are compared in order.
// Both channels idle at random; one test pauses until the block is drained.
// ----------------------------------------------------------------------------
module tb_axis_table_polar_lookup;
  import atpl_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int         TBL_DEPTH  = 64;
  localparam int         RAND_REQS  = 950;
  localparam int         STALL_LIMIT = 6000;

  // atan(2^-i) in units of 2^-24 rad
  localparam longint ATAN_STEP[24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117,
    262123, 131069, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
  localparam longint HALF_TURN_Q24 = 52707179;
  localparam longint ANGLE_CLAMP   = 25736;

  typedef struct {
    logic                      status;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_x;
    logic signed [ANG_W-1:0]   angle;
    logic [DIST_W-1:0]         distance;
    logic [CNT_W-1:0]          point_total;
  } lookup_result_t;

  logic clk;
  logic rst_n;

  atpl_in_if  in_if ();
  atpl_out_if out_if ();

  axis_table_polar_lookup dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // local copy of the axis table
  longint tbl_z [TBL_DEPTH];
  longint tbl_y [TBL_DEPTH];
  longint tbl_x [TBL_DEPTH];
  int     tbl_count;

  lookup_result_t pending_results[$];
  int  mismatch_cnt;
  int  idle_cycles;
  int  hold_cycles;   // long ready-low stretch on the result side
  bit  timed_out;
  bit  steady;        // when set neither side idles

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- model --
  function automatic longint polar_angle(input longint dy, input longint dx);
    longint px, py, acc, xs, ys, r;
    acc = 0;
    if (dx == 0 && dy == 0) return 0;
    px = dx <<< 30;
    py = dy <<< 30;
    // left half plane: turn by pi first, (0, -x) lands on +pi
    if (dx < 0) begin
      px = -px;
      py = -py;
      acc = (dy >= 0) ? HALF_TURN_Q24 : -HALF_TURN_Q24;
    end
    for (int i = 0; i < 24; i++) begin
      xs = px >>> i;
      ys = py >>> i;
      if (py > 0) begin
        px += ys; py -= xs; acc += ATAN_STEP[i];
      end else begin
        px -= ys; py += xs; acc -= ATAN_STEP[i];
      end
    end
    r = (acc + 1024) >>> 11;
    if (r > ANGLE_CLAMP) r = ANGLE_CLAMP;
    if (r < -ANGLE_CLAMP) r = -ANGLE_CLAMP;
    return r;
  endfunction

  function automatic longint unsigned rounded_root(input longint unsigned s);
    longint unsigned rem, root, bitv;
    rem = s;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    if (rem > root) root++;
    return root;
  endfunction

  // Updates the table and returns the answer for one accepted request.
  function automatic lookup_result_t predict_lookup(input logic [1:0] kind,
      input logic signed [COORD_W-1:0] cz, input logic signed [COORD_W-1:0] cy_in,
      input logic signed [COORD_W-1:0] cx_in);
    lookup_result_t res;
    longint z, y, x, cy, cx, t, dy, dx;
    int j, i;
    z = cz; y = cy_in; x = cx_in;
    cy = 0; cx = 0; t = 0;
    res.status = 1'b0;
    res.angle = '0;
    res.distance = '0;
    case (kind)
      REQ_INSERT: begin
        if (tbl_count >= TBL_DEPTH) begin
          res.status = 1'b1;
        end else begin
          // equal z keep arrival order
          j = tbl_count;
          while (j > 0 && tbl_z[j-1] > z) begin
            tbl_z[j] = tbl_z[j-1]; tbl_y[j] = tbl_y[j-1]; tbl_x[j] = tbl_x[j-1];
            j--;
          end
          tbl_z[j] = z; tbl_y[j] = y; tbl_x[j] = x;
          tbl_count++;
        end
      end
      REQ_CLEAR: tbl_count = 0;
      REQ_QUERY: begin
        if (tbl_count == 0) begin
          cy = 0; cx = 0;
        end else if (tbl_count == 1 || z <= tbl_z[0]) begin
          cy = tbl_y[0]; cx = tbl_x[0];
        end else if (z >= tbl_z[tbl_count-1]) begin
          cy = tbl_y[tbl_count-1]; cx = tbl_x[tbl_count-1];
        end else begin
          i = 0;
          while (i + 1 < tbl_count - 1 && tbl_z[i+1] < z) i++;
          if (tbl_z[i+1] > tbl_z[i] && z > tbl_z[i])
            t = ((z - tbl_z[i]) * 65536) / (tbl_z[i+1] - tbl_z[i]);
          cy = tbl_y[i] + ((t * (tbl_y[i+1] - tbl_y[i])) >>> 16);
          cx = tbl_x[i] + ((t * (tbl_x[i+1] - tbl_x[i])) >>> 16);
        end
        dy = y - cy;
        dx = x - cx;
        res.angle = polar_angle(dy, dx);
        res.distance = rounded_root(longint'(dy * dy) + longint'(dx * dx));
      end
      default: ;
    endcase
    res.center_y = cy;
    res.center_x = cx;
    res.point_total = tbl_count;
    return res;
  endfunction

  // -------------------------------------------------------------- driving --
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(input logic [1:0] kind, input logic [COORD_W-1:0] cz,
      input logic [COORD_W-1:0] cy_in, input logic [COORD_W-1:0] cx_in);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.req_type <= kind;
    in_if.coord_z  <= cz;
    in_if.coord_y  <= cy_in;
    in_if.coord_x  <= cx_in;
    do @(posedge clk); while (!in_if.ready);
    pending_results.push_back(predict_lookup(kind, cz, cy_in, cx_in));
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [COORD_W-1:0] any_coord();
    return COORD_W'($urandom());
  endfunction

  // mostly small z values so equal z and short segments show up
  function automatic logic [COORD_W-1:0] table_z();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return COORD_W'($signed($urandom_range(0, 15)) - 8) <<< 8;
    if (r < 8) return COORD_W'($signed($urandom_range(0, 4000)) - 2000);
    return any_coord();
  endfunction

  // ---------------------------------------------------------------- tests --
  task automatic test_directed_cases();
    send_request(REQ_QUERY, 24'h000000, 24'h000000, 24'h000000);   // empty, zero offset
    send_request(REQ_QUERY, 24'h7fffff, 24'h7fffff, 24'h800000);   // empty, far point
    send_request(REQ_UNUSED, 24'hffffff, 24'hffffff, 24'hffffff);
    send_request(REQ_INSERT, 24'h000400, 24'h000100, 24'h000200);
    send_request(REQ_QUERY, 24'h800000, 24'h000100, 24'h000100);   // single point
    send_request(REQ_INSERT, 24'h800000, 24'h800000, 24'h7fffff);   // lowest z
    send_request(REQ_INSERT, 24'h7fffff, 24'h7fffff, 24'h800000);   // highest z
    send_request(REQ_INSERT, 24'h000400, 24'h000300, 24'h000500);   // equal z, behind
    send_request(REQ_QUERY, 24'h800000, 24'h7fffff, 24'h800000);    // at first z
    send_request(REQ_QUERY, 24'h7fffff, 24'h800000, 24'h7fffff);    // at last z
    send_request(REQ_QUERY, 24'h000400, 24'h000300, 24'h000500);    // equal z segment
    send_request(REQ_QUERY, 24'h000200, 24'h000000, 24'h000000);    // interpolated
    send_request(REQ_QUERY, 24'hfff000, 24'h123456, 24'h000000);
    send_request(REQ_CLEAR, 24'h000000, 24'h000000, 24'h000000);
    send_request(REQ_INSERT, 24'h000000, 24'h000000, 24'h000000);
    send_request(REQ_QUERY, 24'h000000, 24'h000000, 24'hffff00);    // negative x on axis: +pi
    send_request(REQ_QUERY, 24'h000000, 24'hffffff, 24'hffff00);    // just below: -pi side
    send_request(REQ_QUERY, 24'h000000, 24'h000100, 24'h000000);
    send_request(REQ_CLEAR, 24'h000000, 24'h000000, 24'h000000);
    send_request(REQ_QUERY, 24'h000100, 24'h000100, 24'h000100);
  endtask

  task automatic test_table_full();
    send_request(REQ_CLEAR, '0, '0, '0);
    for (int n = 0; n < TBL_DEPTH; n++)
      send_request(REQ_INSERT, table_z(), any_coord(), any_coord());
    send_request(REQ_INSERT, any_coord(), any_coord(), any_coord());   // dropped
    for (int n = 0; n < 4; n++)
      send_request(REQ_QUERY, table_z(), any_coord(), any_coord());
  endtask

  // sender holds off until the block has answered everything
  task automatic test_drained_pause();
    drain_results();
    repeat (5) begin
      send_request(REQ_QUERY, table_z(), any_coord(), any_coord());
      drain_results();
    end
  endtask

  task automatic test_random_tables();
    int sent, pts, qs, r;
    logic [1:0] kind;
    sent = 0;
    while (sent < RAND_REQS) begin
      steady = ($urandom_range(0, 5) == 0);
      send_request(REQ_CLEAR, any_coord(), any_coord(), any_coord());
      sent++;
      r = $urandom_range(0, 19);
      pts = (r == 0) ? $urandom_range(60, 66) : $urandom_range(0, 8);
      for (int n = 0; n < pts; n++) begin
        send_request(REQ_INSERT, table_z(), any_coord(), any_coord());
        sent++;
      end
      qs = $urandom_range(2, 12);
      for (int n = 0; n < qs; n++) begin
        // a little noise: any code, unused one included
        kind = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(0, 3)) : REQ_QUERY;
        send_request(kind, table_z(), any_coord(), any_coord());
        sent++;
      end
    end
    steady = 1'b0;
  endtask

  // --------------------------------------------------------------- result --
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_cycles  <= 0;
    end else if (hold_cycles > 0) begin
      out_if.ready <= 1'b0;
      hold_cycles  <= hold_cycles - 1;
    end else if (!steady && $urandom_range(0, 49) == 0) begin
      out_if.ready <= 1'b0;
      hold_cycles  <= $urandom_range(10, 40);
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      out_if.ready <= ($urandom_range(0, 9) == 0);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    lookup_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result at %0t: point_total=%0d", $time, out_if.point_total);
      end else begin
        want = pending_results.pop_front();
        if (out_if.status !== want.status || out_if.center_y !== want.center_y ||
            out_if.center_x !== want.center_x || out_if.angle !== want.angle ||
            out_if.distance !== want.distance || out_if.point_total !== want.point_total) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch at %0t: exp st=%0d cy=%0d cx=%0d ang=%0d dist=%0d n=%0d",
                     $time, want.status, want.center_y, want.center_x, want.angle,
                     want.distance, want.point_total,
                     "\n  got st=%0d cy=%0d cx=%0d ang=%0d dist=%0d n=%0d",
                     out_if.status, out_if.center_y, out_if.center_x, out_if.angle,
                     out_if.distance, out_if.point_total);
        end
      end
    end
  end

  // watchdog: cycles with no request and no result accepted
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT && !timed_out) begin
      timed_out <= 1'b1;
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    steady = 1'b0;
    tbl_count = 0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.req_type = REQ_INSERT;
    in_if.coord_z = '0;
    in_if.coord_y = '0;
    in_if.coord_x = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_table_full();
    test_drained_pause();
    test_random_tables();

    drain_results();
    repeat (200) @(posedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/atpl_pkg.sv
design/atpl_if.sv
design/atpl_polar.sv
design/axis_table_polar_lookup.sv
design/atpl_checker.sv
dv/tb_axis_table_polar_lookup.sv
